// ===== rtl/r2cfp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the resp2 command frame parser
// no dependencies; used by r2cfp_csr and resp2_command_frame_parser
package r2cfp_pkg;

   // parser phases
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RESYNC    = 4'd1,
      PH_ARR_NUM   = 4'd2,
      PH_ARR_LF    = 4'd3,
      PH_BULK_LEAD = 4'd4,
      PH_BULK_NUM  = 4'd5,
      PH_BULK_LF   = 4'd6,
      PH_PAYLOAD   = 4'd7,
      PH_SKIP      = 4'd8
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
   localparam logic [1:0] KIND_EMPTY_ELEM = 2'd1;
   localparam logic [1:0] KIND_EMPTY_CMD = 2'd2;
   localparam logic [1:0] KIND_ERROR     = 2'd3;

   // protocol characters
   localparam logic [7:0] CH_BULK  = 8'h24;
   localparam logic [7:0] CH_ARRAY = 8'h2A;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // register indexes (paddr[2])
   localparam logic REG_MAX_ELEMENTS    = 1'b0;
   localparam logic REG_MAX_BULK_LENGTH = 1'b1;

   localparam logic [15:0] MAX_ELEMENTS_RESET    = 16'd64;
   localparam logic [29:0] MAX_BULK_LENGTH_RESET = 30'h2000_0000;

   // limits handed from the register file to the parser
   typedef struct packed {
      logic [15:0] max_elements;
      logic [29:0] max_bulk_length;
   } cfg_type;

endpackage

// ===== rtl/r2cfp_csr.sv =====
`timescale 1ns / 1ps
// register file for the resp2 command frame parser: apb-style access
// depends on r2cfp_pkg
module r2cfp_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output r2cfp_pkg::cfg_type cfg
);

   logic [15:0] max_elements_ff;
   logic [29:0] max_bulk_length_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_elements_ff    <= r2cfp_pkg::MAX_ELEMENTS_RESET;
         max_bulk_length_ff <= r2cfp_pkg::MAX_BULK_LENGTH_RESET;
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            r2cfp_pkg::REG_MAX_ELEMENTS: begin
               max_elements_ff <= csr_pwdata[15:0];
            end
            r2cfp_pkg::REG_MAX_BULK_LENGTH: begin
               max_bulk_length_ff <= csr_pwdata[29:0];
            end
            default: begin
               max_elements_ff <= max_elements_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         r2cfp_pkg::REG_MAX_ELEMENTS:    csr_prdata = {16'd0, max_elements_ff};
         r2cfp_pkg::REG_MAX_BULK_LENGTH: csr_prdata = {2'd0, max_bulk_length_ff};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   assign cfg.max_elements    = max_elements_ff;
   assign cfg.max_bulk_length = max_bulk_length_ff;

endmodule

// ===== rtl/resp2_command_frame_parser.sv =====
`timescale 1ns / 1ps
// resp2 command frame parser top level: byte-stream parser with result register
// depends on r2cfp_pkg and r2cfp_csr
//
// usage
// - req_* carries the raw request stream, one byte per word
// - rsp_* carries one word per payload byte, empty element, empty command
//   or protocol error; tlast marks the word that completes a command
// - csr_* sets the element count limit (addr 0) and bulk length limit (addr 4)
// - every byte is parsed in the cycle it is accepted; its result word, if any,
//   sits in the result register from the next cycle on
// - throughput is one byte per cycle; the only limit is the single result
//   register, which lets a new byte in whenever it is empty or being drained
// - while rsp_tready is low and a result is held, req_tready drops and the
//   parser state is frozen; bytes that give no result still need the slot free
// - reset returns the parser to waiting for '*', clears the result register
//   and loads the limits with 64 elements and 2^29 bytes
// - after a protocol error the parser drops bytes silently until the next '*'
module resp2_command_frame_parser #(
   parameter int LENGTH_BITS = 32,
   parameter int INDEX_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_byte, [23:8] element_index
   output logic [3:0]  rsp_tuser,   // [1:0] kind, [2] element_first, [3] element_last
   output logic        rsp_tlast,   // command_last
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // accumulator holds both counts and lengths
   localparam int ACC_BITS = (LENGTH_BITS > INDEX_BITS) ? LENGTH_BITS : INDEX_BITS;
   localparam int WIDE_BITS = ACC_BITS + 32;
   localparam logic [ACC_BITS-1:0] ACC_ONES = '1;
   localparam logic [ACC_BITS-1:0] IDX_MASK = ACC_ONES >> (ACC_BITS - INDEX_BITS);
   localparam logic [ACC_BITS-1:0] LEN_MASK = ACC_ONES >> (ACC_BITS - LENGTH_BITS);

   r2cfp_pkg::cfg_type cfg;

   r2cfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // parser state
   r2cfp_pkg::phase_type   phase_ff, phase_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic [INDEX_BITS-1:0]  elem_left_ff, elem_left_in;
   logic [INDEX_BITS-1:0]  cur_elem_ff, cur_elem_in;
   logic [LENGTH_BITS-1:0] pay_left_ff, pay_left_in;
   logic [1:0]             skip_left_ff, skip_left_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff;
   logic [7:0]  rsp_byte_ff;
   logic [15:0] rsp_index_ff;
   logic        rsp_first_ff, rsp_last_ff, rsp_cmd_ff;

   // per-byte result
   logic        res_valid;
   logic [1:0]  res_kind;
   logic [7:0]  res_byte;
   logic [15:0] res_index;
   logic        res_first, res_last, res_cmd;

   logic                   req_fire;
   logic [7:0]             b;
   logic                   is_digit;
   logic [3:0]             digit;
   logic [ACC_BITS+3:0]    acc_next;
   logic [WIDE_BITS-1:0]   me_wide, mbl_wide;
   logic [ACC_BITS-1:0]    count_lim, length_lim;
   logic                   count_over, length_over;
   logic [INDEX_BITS+15:0] idx_ext;
   logic                   elem_is_last;
   logic [LENGTH_BITS-1:0] pay_dec;
   logic [1:0]             skip_dec;
   logic [INDEX_BITS-1:0]  elem_dec;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign b          = req_tdata;

   // decimal digit step: acc * 10 + digit as two shifts and two adds
   assign is_digit = (b >= r2cfp_pkg::CH_ZERO) && (b <= r2cfp_pkg::CH_NINE);
   assign digit    = 4'(b - r2cfp_pkg::CH_ZERO);
   assign acc_next = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + (ACC_BITS+4)'(digit);

   // effective limits, capped at what the counters can hold
   assign me_wide    = WIDE_BITS'(cfg.max_elements);
   assign mbl_wide   = WIDE_BITS'(cfg.max_bulk_length);
   assign count_lim  = (me_wide < WIDE_BITS'(IDX_MASK)) ? me_wide[ACC_BITS-1:0] : IDX_MASK;
   assign length_lim = (mbl_wide < WIDE_BITS'(LEN_MASK)) ? mbl_wide[ACC_BITS-1:0] : LEN_MASK;
   assign count_over  = acc_next > {4'd0, count_lim};
   assign length_over = acc_next > {4'd0, length_lim};

   // element index is reported on 16 bits whatever the counter width
   assign idx_ext      = {16'd0, cur_elem_ff};
   assign elem_is_last = (elem_left_ff == INDEX_BITS'(1));

   assign pay_dec  = (pay_left_ff == '0) ? '0 : pay_left_ff - LENGTH_BITS'(1);
   assign skip_dec = (skip_left_ff == 2'd0) ? 2'd0 : skip_left_ff - 2'd1;
   assign elem_dec = (elem_left_ff == '0) ? '0 : elem_left_ff - INDEX_BITS'(1);

   always_comb begin
      logic fail;
      fail          = 1'b0;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      digit_seen_in = digit_seen_ff;
      elem_left_in  = elem_left_ff;
      cur_elem_in   = cur_elem_ff;
      pay_left_in   = pay_left_ff;
      skip_left_in  = skip_left_ff;
      res_valid     = 1'b0;
      res_kind      = r2cfp_pkg::KIND_PAYLOAD;
      res_byte      = 8'd0;
      res_index     = 16'd0;
      res_first     = 1'b0;
      res_last      = 1'b0;
      res_cmd       = 1'b0;

      unique case (phase_ff)
         r2cfp_pkg::PH_IDLE: begin
            if (b != r2cfp_pkg::CH_ARRAY) begin
               fail = 1'b1;
            end else begin
               acc_in        = '0;
               digit_seen_in = 1'b0;
               phase_in      = r2cfp_pkg::PH_ARR_NUM;
            end
         end
         r2cfp_pkg::PH_RESYNC: begin
            if (b == r2cfp_pkg::CH_ARRAY) begin
               acc_in        = '0;
               digit_seen_in = 1'b0;
               phase_in      = r2cfp_pkg::PH_ARR_NUM;
            end
         end
         r2cfp_pkg::PH_ARR_NUM: begin
            if (is_digit) begin
               if (count_over) begin
                  fail = 1'b1;
               end else begin
                  acc_in        = acc_next[ACC_BITS-1:0];
                  digit_seen_in = 1'b1;
               end
            end else if (b == r2cfp_pkg::CH_CR && digit_seen_ff) begin
               phase_in = r2cfp_pkg::PH_ARR_LF;
            end else begin
               fail = 1'b1;
            end
         end
         r2cfp_pkg::PH_ARR_LF: begin
            if (b != r2cfp_pkg::CH_LF) begin
               fail = 1'b1;
            end else if (acc_ff == '0) begin
               // empty array
               phase_in  = r2cfp_pkg::PH_IDLE;
               res_valid = 1'b1;
               res_kind  = r2cfp_pkg::KIND_EMPTY_CMD;
               res_cmd   = 1'b1;
            end else begin
               elem_left_in = acc_ff[INDEX_BITS-1:0];
               cur_elem_in  = '0;
               phase_in     = r2cfp_pkg::PH_BULK_LEAD;
            end
         end
         r2cfp_pkg::PH_BULK_LEAD: begin
            if (b != r2cfp_pkg::CH_BULK) begin
               fail = 1'b1;
            end else begin
               acc_in        = '0;
               digit_seen_in = 1'b0;
               phase_in      = r2cfp_pkg::PH_BULK_NUM;
            end
         end
         r2cfp_pkg::PH_BULK_NUM: begin
            if (is_digit) begin
               if (length_over) begin
                  fail = 1'b1;
               end else begin
                  acc_in        = acc_next[ACC_BITS-1:0];
                  digit_seen_in = 1'b1;
               end
            end else if (b == r2cfp_pkg::CH_CR && digit_seen_ff) begin
               phase_in = r2cfp_pkg::PH_BULK_LF;
            end else begin
               fail = 1'b1;
            end
         end
         r2cfp_pkg::PH_BULK_LF: begin
            if (b != r2cfp_pkg::CH_LF) begin
               fail = 1'b1;
            end else if (acc_ff == '0) begin
               // empty element, its two trailing bytes still follow
               skip_left_in = 2'd2;
               phase_in     = r2cfp_pkg::PH_SKIP;
               res_valid    = 1'b1;
               res_kind     = r2cfp_pkg::KIND_EMPTY_ELEM;
               res_index    = idx_ext[15:0];
               res_last     = 1'b1;
               res_cmd      = elem_is_last;
            end else begin
               pay_left_in = acc_ff[LENGTH_BITS-1:0];
               phase_in    = r2cfp_pkg::PH_PAYLOAD;
            end
         end
         r2cfp_pkg::PH_PAYLOAD: begin
            pay_left_in = pay_dec;
            if (pay_dec == '0) begin
               skip_left_in = 2'd2;
               phase_in     = r2cfp_pkg::PH_SKIP;
            end
            res_valid = 1'b1;
            res_kind  = r2cfp_pkg::KIND_PAYLOAD;
            res_byte  = b;
            res_index = idx_ext[15:0];
            // accumulator still holds the element length
            res_first = (ACC_BITS'(pay_left_ff) == acc_ff);
            res_last  = (pay_left_ff[LENGTH_BITS-1:1] == '0);
            res_cmd   = (pay_left_ff[LENGTH_BITS-1:1] == '0) && elem_is_last;
         end
         r2cfp_pkg::PH_SKIP: begin
            skip_left_in = skip_dec;
            if (skip_dec == 2'd0) begin
               elem_left_in = elem_dec;
               cur_elem_in  = cur_elem_ff + INDEX_BITS'(1);
               phase_in     = (elem_dec == '0) ? r2cfp_pkg::PH_IDLE
                                               : r2cfp_pkg::PH_BULK_LEAD;
            end
         end
         default: begin
            phase_in = r2cfp_pkg::PH_RESYNC;
         end
      endcase

      if (fail) begin
         phase_in  = r2cfp_pkg::PH_RESYNC;
         res_valid = 1'b1;
         res_kind  = r2cfp_pkg::KIND_ERROR;
         res_byte  = 8'd0;
         res_index = 16'd0;
         res_first = 1'b0;
         res_last  = 1'b0;
         res_cmd   = 1'b0;
      end
   end

   // parser state advances only on an accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= r2cfp_pkg::PH_IDLE;
         acc_ff        <= '0;
         digit_seen_ff <= 1'b0;
         elem_left_ff  <= '0;
         cur_elem_ff   <= '0;
         pay_left_ff   <= '0;
         skip_left_ff  <= 2'd0;
      end else if (req_fire) begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         digit_seen_ff <= digit_seen_in;
         elem_left_ff  <= elem_left_in;
         cur_elem_ff   <= cur_elem_in;
         pay_left_ff   <= pay_left_in;
         skip_left_ff  <= skip_left_in;
      end
   end

   // result register: filled by a byte with a result, drained by the receiver
   assign rsp_valid_in = (req_fire & res_valid) | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && res_valid) begin
         rsp_kind_ff  <= res_kind;
         rsp_byte_ff  <= res_byte;
         rsp_index_ff <= res_index;
         rsp_first_ff <= res_first;
         rsp_last_ff  <= res_last;
         rsp_cmd_ff   <= res_cmd;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_index_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_last_ff, rsp_first_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_cmd_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the resp2 command frame parser
// depends on r2cfp_pkg and the resp2_command_frame_parser rtl; reads no files

module tb;

   // one expected result word, field for field
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] index;
      logic        is_first;
      logic        is_last;
      logic        is_cmd;
   } parse_result_type;

   // outcome of one header character
   typedef enum logic [1:0] {HDR_MORE, HDR_DONE, HDR_BAD} header_step_type;

   // clock, reset and dut inputs, all known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;      // [7:0] in_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;             // [7:0] payload_byte, [23:8] element_index
   logic [3:0]  rsp_tuser;             // [1:0] kind, [2] element_first, [3] element_last
   logic        rsp_tlast;             // command_last
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state, mirrors the parser after reset
   r2cfp_pkg::phase_type ph = r2cfp_pkg::PH_IDLE;
   logic [31:0] acc = 32'd0;
   logic        seen = 1'b0;
   logic [15:0] elems_left = 16'd0;
   logic [15:0] cur_elem = 16'd0;
   logic [31:0] pay_left = 32'd0;
   logic [1:0]  skip_left = 2'd0;
   logic [15:0] lim_elements = r2cfp_pkg::MAX_ELEMENTS_RESET;
   logic [29:0] lim_length = r2cfp_pkg::MAX_BULK_LENGTH_RESET;

   parse_result_type parsed_results[$];   // words the parser owes us, oldest first
   logic [7:0]       frame_bytes[$];      // one generated command, ready to send

   int mismatch_count = 0;
   int useful_bytes = 0;               // bytes not simply dropped during resync
   int sender_idle_pct = 17;
   int receiver_stall_pct = 77;

   always #6 clock = ~clock;

   resp2_command_frame_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------- reporting

   // one line per mismatch, and a count
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // ---------------------------------------------------------------- predictor

   task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic [15:0] index, input logic is_first,
                              input logic is_last, input logic is_cmd);
      parse_result_type r;
      r.kind = kind;
      r.data = data;
      r.index = index;
      r.is_first = is_first;
      r.is_last = is_last;
      r.is_cmd = is_cmd;
      parsed_results = {parsed_results, r};
   endtask

   // any protocol error drops the parser into resync
   task automatic protocol_error();
      ph = r2cfp_pkg::PH_RESYNC;
      push_result(r2cfp_pkg::KIND_ERROR, 8'd0, 16'd0, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic start_number(input r2cfp_pkg::phase_type next);
      acc = 32'd0;
      seen = 1'b0;
      ph = next;
   endtask

   // decimal count or length character; the limit check comes on each digit
   function automatic header_step_type header_char(input logic [7:0] b,
                                                   input logic [31:0] limit);
      logic [63:0] v;
      if (b >= r2cfp_pkg::CH_ZERO && b <= r2cfp_pkg::CH_NINE) begin
         v = 64'(acc) * 64'd10 + 64'(b - r2cfp_pkg::CH_ZERO);
         if (v > 64'(limit))
            return HDR_BAD;
         acc = v[31:0];
         seen = 1'b1;
         return HDR_MORE;
      end
      if (b == r2cfp_pkg::CH_CR && seen)
         return HDR_DONE;
      return HDR_BAD;
   endfunction

   // advance the parser model by one accepted byte and queue its result word, if any
   task automatic parse_stream_byte(input logic [7:0] b);
      header_step_type hs;
      logic            is_first;
      logic            is_last;
      case (ph)
         r2cfp_pkg::PH_IDLE: begin
            if (b != r2cfp_pkg::CH_ARRAY)
               protocol_error();
            else
               start_number(r2cfp_pkg::PH_ARR_NUM);
         end
         r2cfp_pkg::PH_RESYNC: begin
            if (b == r2cfp_pkg::CH_ARRAY)
               start_number(r2cfp_pkg::PH_ARR_NUM);
         end
         r2cfp_pkg::PH_ARR_NUM: begin
            hs = header_char(b, 32'(lim_elements));
            if (hs == HDR_BAD)
               protocol_error();
            else if (hs == HDR_DONE)
               ph = r2cfp_pkg::PH_ARR_LF;
         end
         r2cfp_pkg::PH_ARR_LF: begin
            if (b != r2cfp_pkg::CH_LF) begin
               protocol_error();
            end else if (acc == 32'd0) begin
               // empty array, no trailing bytes follow
               ph = r2cfp_pkg::PH_IDLE;
               push_result(r2cfp_pkg::KIND_EMPTY_CMD, 8'd0, 16'd0, 1'b0, 1'b0, 1'b1);
            end else begin
               elems_left = acc[15:0];
               cur_elem = 16'd0;
               ph = r2cfp_pkg::PH_BULK_LEAD;
            end
         end
         r2cfp_pkg::PH_BULK_LEAD: begin
            if (b != r2cfp_pkg::CH_BULK)
               protocol_error();
            else
               start_number(r2cfp_pkg::PH_BULK_NUM);
         end
         r2cfp_pkg::PH_BULK_NUM: begin
            hs = header_char(b, 32'(lim_length));
            if (hs == HDR_BAD)
               protocol_error();
            else if (hs == HDR_DONE)
               ph = r2cfp_pkg::PH_BULK_LF;
         end
         r2cfp_pkg::PH_BULK_LF: begin
            if (b != r2cfp_pkg::CH_LF) begin
               protocol_error();
            end else if (acc == 32'd0) begin
               // empty element still owns two trailing bytes
               skip_left = 2'd2;
               ph = r2cfp_pkg::PH_SKIP;
               push_result(r2cfp_pkg::KIND_EMPTY_ELEM, 8'd0, cur_elem, 1'b0, 1'b1,
                           elems_left == 16'd1);
            end else begin
               pay_left = acc;
               ph = r2cfp_pkg::PH_PAYLOAD;
            end
         end
         r2cfp_pkg::PH_PAYLOAD: begin
            is_first = (pay_left == acc);
            is_last = (pay_left <= 32'd1);
            if (pay_left > 32'd0)
               pay_left--;
            if (pay_left == 32'd0) begin
               skip_left = 2'd2;
               ph = r2cfp_pkg::PH_SKIP;
            end
            push_result(r2cfp_pkg::KIND_PAYLOAD, b, cur_elem, is_first, is_last,
                        is_last && elems_left == 16'd1);
         end
         r2cfp_pkg::PH_SKIP: begin
            // trailing bytes go unchecked, even after the last element
            if (skip_left > 2'd0)
               skip_left--;
            if (skip_left == 2'd0) begin
               if (elems_left > 16'd0)
                  elems_left--;
               cur_elem++;
               ph = (elems_left == 16'd0) ? r2cfp_pkg::PH_IDLE : r2cfp_pkg::PH_BULK_LEAD;
            end
         end
         default: ph = r2cfp_pkg::PH_RESYNC;
      endcase
   endtask

   // ---------------------------------------------------------------- drivers

   // offers one byte on req_*; entered and left just after a rising edge
   task automatic send_byte(input logic [7:0] b);
      logic accepted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      accepted = 1'b0;
      while (!accepted) begin
         // inputs and outputs only move at rising edges, so mid-cycle is safe
         @(negedge clock);
         accepted = req_tready;
         @(posedge clock);
      end
      if (ph != r2cfp_pkg::PH_RESYNC || b == r2cfp_pkg::CH_ARRAY)
         useful_bytes++;
      parse_stream_byte(b);
   endtask

   task automatic send_text(input string s);
      foreach (s[i])
         send_byte(s[i]);
   endtask

   // lead character, decimal digits, cr, lf
   task automatic send_header(input logic [7:0] lead, input string digits);
      send_byte(lead);
      send_text(digits);
      send_byte(r2cfp_pkg::CH_CR);
      send_byte(r2cfp_pkg::CH_LF);
   endtask

   // one apb transfer left with psel high, so transfers can run back to back
   task automatic csr_access(input logic idx, input logic is_write, input logic [31:0] value);
      logic [31:0] got;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      if (is_write) begin
         if (idx == r2cfp_pkg::REG_MAX_ELEMENTS)
            lim_elements = value[15:0];
         else
            lim_length = value[29:0];
      end else if (idx == r2cfp_pkg::REG_MAX_ELEMENTS) begin
         check_field("max_elements readback", got, 32'(lim_elements));
      end else begin
         check_field("max_bulk_length readback", got, 32'(lim_length));
      end
   endtask

   task automatic csr_release();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_write_check(input logic idx, input logic [31:0] value);
      csr_access(idx, 1'b1, value);
      csr_access(idx, 1'b0, 32'd0);
      csr_release();
   endtask

   // stop sending, let every owed word drain, then let the parser settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (parsed_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // a word is taken at the next rising edge when valid and ready are both
   // high mid-cycle; compare it against the oldest prediction
   always @(negedge clock) begin
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (parsed_results.size() == 0) begin
            report_mismatch("result word with nothing expected",
                            {3'd0, rsp_tlast, rsp_tuser, rsp_tdata}, 32'd0);
         end else begin
            want = parsed_results.pop_front();
            check_field("kind", rsp_tuser[1:0], want.kind);
            check_field("payload_byte", rsp_tdata[7:0], want.data);
            check_field("element_index", rsp_tdata[23:8], want.index);
            check_field("element_first", rsp_tuser[2], want.is_first);
            check_field("element_last", rsp_tuser[3], want.is_last);
            check_field("command_last", rsp_tlast, want.is_cmd);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic append_byte(input logic [7:0] v);
      frame_bytes = {frame_bytes, v};
   endtask

   // decimal text, sometimes with one leading zero
   task automatic push_number(input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(9) == 0)
         append_byte(r2cfp_pkg::CH_ZERO);
      foreach (s[i])
         append_byte(s[i]);
   endtask

   task automatic push_header(input logic [7:0] lead, input int unsigned v);
      append_byte(lead);
      push_number(v);
      append_byte(r2cfp_pkg::CH_CR);
      append_byte(r2cfp_pkg::CH_LF);
   endtask

   // one command with random content; about a quarter are noisy or broken
   task automatic make_frame();
      int unsigned n;
      int unsigned len;
      int          mode;
      int          bad_elem;
      int          cut;
      frame_bytes.delete();
      mode = $urandom_range(99);
      bad_elem = $urandom_range(3);
      // stray bytes ahead of the command
      if (mode < 8)
         repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(255)));
      if ($urandom_range(9) == 0)
         n = 0;
      else
         n = $urandom_range(1, ($urandom_range(7) == 0) ? 12 : 4);
      if (n > lim_elements)
         n = lim_elements;
      // count just past its limit
      if (mode >= 8 && mode < 12)
         n = lim_elements + 1 + $urandom_range(20);
      push_header(r2cfp_pkg::CH_ARRAY, n);
      for (int k = 0; k < n && k < 12; k++) begin
         if ($urandom_range(5) == 0)
            len = 0;
         else
            len = $urandom_range(1, ($urandom_range(15) == 0) ? 40 : 8);
         if (len > lim_length)
            len = lim_length;
         // length just past its limit
         if (mode >= 12 && mode < 16 && k == bad_elem)
            len = lim_length + 1 + $urandom_range(20);
         push_header(r2cfp_pkg::CH_BULK, len);
         for (int j = 0; j < len && j < 48; j++)
            append_byte(8'($urandom_range(255)));
         if ($urandom_range(4) == 0) begin
            append_byte(8'($urandom_range(255)));
            append_byte(8'($urandom_range(255)));
         end else begin
            append_byte(r2cfp_pkg::CH_CR);
            append_byte(r2cfp_pkg::CH_LF);
         end
      end
      // one byte overwritten anywhere in the command
      if (mode >= 16 && mode < 22)
         frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(255));
      // command cut short, the next one barges in
      if (mode >= 22 && mode < 26) begin
         cut = $urandom_range(1, frame_bytes.size());
         while (frame_bytes.size() > cut)
            void'(frame_bytes.pop_back());
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_register_reset();
      csr_access(r2cfp_pkg::REG_MAX_ELEMENTS, 1'b0, 32'd0);
      csr_access(r2cfp_pkg::REG_MAX_BULK_LENGTH, 1'b0, 32'd0);
      csr_release();
   endtask

   task automatic test_basic_frames();
      send_text("A");                        // bad lead byte while idle
      send_header(r2cfp_pkg::CH_ARRAY, "0"); // resync on '*', then empty array
      send_header(r2cfp_pkg::CH_ARRAY, "2");
      send_header(r2cfp_pkg::CH_BULK, "0");  // empty element plus its trailing pair
      send_byte(r2cfp_pkg::CH_CR);
      send_byte(r2cfp_pkg::CH_LF);
      send_header(r2cfp_pkg::CH_BULK, "02"); // leading zero, extreme payload values
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text("zz");                       // trailing bytes after the command end
   endtask

   task automatic test_header_errors();
      send_byte(r2cfp_pkg::CH_ARRAY);        // cr before any digit
      send_byte(r2cfp_pkg::CH_CR);
      send_text("*1x");                      // non-digit in the count
      send_text("*1");                       // '*' where lf is due, consumed
      send_byte(r2cfp_pkg::CH_CR);
      send_byte(r2cfp_pkg::CH_ARRAY);
      send_text("*-");                       // signs are rejected
      send_text("*65");                      // one past the reset count limit
      send_header(r2cfp_pkg::CH_ARRAY, "1"); // '*' where '$' is due, consumed
      send_byte(r2cfp_pkg::CH_ARRAY);
      send_header(r2cfp_pkg::CH_ARRAY, "1"); // non-digit in a length
      send_text("$5x");
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input logic [15:0] n_lim, input logic [29:0] len_lim,
                                      input int byte_goal);
      int start_count;
      drain_results();
      csr_write_check(r2cfp_pkg::REG_MAX_ELEMENTS, 32'(n_lim));
      csr_write_check(r2cfp_pkg::REG_MAX_BULK_LENGTH, 32'(len_lim));
      sender_idle_pct = send_pct;
      receiver_stall_pct = stall_pct;
      start_count = useful_bytes;
      while (useful_bytes - start_count < byte_goal) begin
         make_frame();
         foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_register_reset();
      test_basic_frames();
      test_header_errors();

      // idling: slow receiver first, then slow sender, then full rate
      test_random_traffic(17, 77, 16'd64, 30'h2000_0000, 300);
      test_random_traffic(17, 77, 16'd3, 30'd5, 300);
      test_random_traffic(77, 17, 16'd65535, 30'h2000_0000, 300);
      test_random_traffic(77, 17, 16'd0, 30'd0, 100);
      test_random_traffic(0, 0, 16'd1, 30'd1, 300);
      test_random_traffic(0, 0, 16'd12, 30'd40, 300);

      drain_results();
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
